// ===== rtl/dqpb_pkg.sv =====
// Shared types and constants of the DNS query packet builder.
`default_nettype none

package dqpb_pkg;

   // Request command codes on req_cmd
   localparam logic [1:0] CMD_START  = 2'd0;
   localparam logic [1:0] CMD_CHAR   = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic [7:0] DOT_CHAR = 8'h2E;

   // Label length counter width (labels hold at most 63 characters)
   localparam int CountW = 6;

   // Header words after the query id
   localparam logic [15:0] FLAGS_WORD   = 16'h0100;
   localparam logic [15:0] QDCOUNT_WORD = 16'h0001;
   localparam logic [15:0] ZERO_WORD    = 16'h0000;
   localparam logic [2:0]  HDR_LAST     = 3'd5;

   // Trailer: terminator, type high, type low, class high, class low
   localparam logic [7:0] ZERO_BYTE     = 8'h00;
   localparam logic [7:0] CLASS_IN_LOW  = 8'h01;
   localparam logic [2:0] TRL_TYPE_HIGH = 3'd1;
   localparam logic [2:0] TRL_TYPE_LOW  = 3'd2;
   localparam logic [2:0] TRL_CLASS_HI  = 3'd3;
   localparam logic [2:0] TRL_LAST      = 3'd4;

   localparam logic [1:0] COUNT_FULL = 2'd2;
   localparam logic [1:0] COUNT_HALF = 2'd1;

   typedef enum logic [1:0] {
      OP_START,
      OP_CHAR,
      OP_DOT,
      OP_FINISH
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [7:0]  name_char;
      logic [15:0] query_id;
      logic [7:0]  query_type;
   } item_type;

endpackage

`default_nettype wire

// ===== rtl/dqpb_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
`default_nettype none

module dqpb_front (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  wire  [1:0]          req_cmd,
   input  wire  [7:0]          req_name_char,
   input  wire  [15:0]         req_query_id,
   input  wire  [7:0]          req_query_type,
   output logic                q_valid,
   input  wire                 q_ready,
   output dqpb_pkg::item_type  q_item
);

   dqpb_pkg::item_type q_mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;

   dqpb_pkg::item_type item_in;
   logic               push;
   logic               pop;
   logic               used_cmd;

   // Classify; the unused command is taken and dropped
   always_comb begin
      item_in.name_char  = req_name_char;
      item_in.query_id   = req_query_id;
      item_in.query_type = req_query_type;
      used_cmd           = 1'b1;
      unique case (req_cmd)
         dqpb_pkg::CMD_START: begin
            item_in.op = dqpb_pkg::OP_START;
         end
         dqpb_pkg::CMD_CHAR: begin
            item_in.op = (req_name_char == dqpb_pkg::DOT_CHAR) ?
                         dqpb_pkg::OP_DOT : dqpb_pkg::OP_CHAR;
         end
         dqpb_pkg::CMD_FINISH: begin
            item_in.op = dqpb_pkg::OP_FINISH;
         end
         default: begin
            item_in.op = dqpb_pkg::OP_CHAR;
            used_cmd   = 1'b0;
         end
      endcase
   end

   assign req_ready = (fill_ff != 2'd2);
   assign q_valid   = (fill_ff != 2'd0);
   assign q_item    = q_mem_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready && used_cmd;
   assign pop       = q_valid && q_ready;

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem_ff[wr_ptr_ff] <= item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         if (push && !pop) begin
            fill_ff <= fill_ff + 2'd1;
         end else if (pop && !push) begin
            fill_ff <= fill_ff - 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/dqpb_back.sv =====
// Back end: label buffer, byte sequencer and output register.
`default_nettype none

module dqpb_back #(
   parameter int LABEL_MAX = 63
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 q_valid,
   output logic                q_ready,
   input  dqpb_pkg::item_type  q_item,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output logic [15:0]         rsp_out_word,
   output logic [1:0]          rsp_byte_count,
   output logic                rsp_last_word,
   output logic                rsp_status
);

   localparam int AddrW = (LABEL_MAX > 1) ? $clog2(LABEL_MAX) : 1;
   localparam logic [dqpb_pkg::CountW-1:0] LabelMaxC = dqpb_pkg::CountW'(LABEL_MAX);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HDR,
      ST_FLUSH_LEN,
      ST_FLUSH_DATA,
      ST_TRAIL,
      ST_PAD
   } state_type;

   state_type                     state_ff;
   logic [dqpb_pkg::CountW-1:0]   count_ff;
   logic [dqpb_pkg::CountW-1:0]   data_idx_ff;
   logic [2:0]                    step_ff;
   logic [7:0]                    held_byte_ff;
   logic                          held_valid_ff;
   logic                          overflow_ff;
   logic                          finish_ff;
   logic [7:0]                    type_hold_ff;
   logic [15:0]                   id_ff;
   logic                          rsp_valid_ff;
   logic [15:0]                   rsp_word_ff;
   logic [1:0]                    rsp_count_ff;
   logic                          rsp_last_ff;
   logic                          rsp_status_ff;

   logic [7:0]                    label_mem [LABEL_MAX];
   logic [7:0]                    rd_data_ff;

   logic                          out_free;
   logic                          byte_take;
   logic                          emit_word;
   logic                          word_load;
   logic [7:0]                    cur_byte;
   logic                          cur_last;
   logic                          label_end;
   logic [dqpb_pkg::CountW-1:0]   data_next;
   logic                          mem_we;
   logic                          mem_re;
   logic [AddrW-1:0]              mem_raddr;
   logic                          run_status;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign byte_take  = !held_valid_ff || out_free;
   assign emit_word  = held_valid_ff && out_free;
   assign q_ready    = (state_ff == ST_IDLE);
   assign data_next  = data_idx_ff + 1'b1;
   assign label_end  = ({1'b0, data_idx_ff} + 7'd1) == {1'b0, count_ff};
   assign run_status = finish_ff && overflow_ff;

   // A new word enters the output register this cycle
   assign word_load  = ((state_ff == ST_FLUSH_LEN || state_ff == ST_FLUSH_DATA ||
                         state_ff == ST_TRAIL) && emit_word) ||
                       ((state_ff == ST_HDR || state_ff == ST_PAD) && out_free);

   // Current byte of the sequence and whether a word formed with it ends the run
   always_comb begin
      cur_byte = dqpb_pkg::ZERO_BYTE;
      cur_last = 1'b0;
      unique case (state_ff)
         ST_FLUSH_LEN: begin
            cur_byte = {{(8 - dqpb_pkg::CountW){1'b0}}, count_ff};
            cur_last = !finish_ff && (count_ff <= 6'd1);
         end
         ST_FLUSH_DATA: begin
            cur_byte = rd_data_ff;
            cur_last = !finish_ff &&
                       (({1'b0, data_idx_ff} + 7'd2) >= {1'b0, count_ff});
         end
         ST_TRAIL: begin
            unique case (step_ff)
               dqpb_pkg::TRL_TYPE_LOW: cur_byte = type_hold_ff;
               dqpb_pkg::TRL_LAST:     cur_byte = dqpb_pkg::CLASS_IN_LOW;
               default:                cur_byte = dqpb_pkg::ZERO_BYTE;
            endcase
            cur_last = (step_ff == dqpb_pkg::TRL_LAST);
         end
         default: begin
            cur_byte = dqpb_pkg::ZERO_BYTE;
            cur_last = 1'b0;
         end
      endcase
   end

   // Label buffer port control
   always_comb begin
      mem_we    = (state_ff == ST_IDLE) && q_valid && (q_item.op == dqpb_pkg::OP_CHAR)
                  && (count_ff < LabelMaxC);
      mem_re    = 1'b0;
      mem_raddr = '0;
      if (state_ff == ST_FLUSH_LEN && byte_take) begin
         mem_re = 1'b1;
      end else if (state_ff == ST_FLUSH_DATA && byte_take && !label_end) begin
         mem_re    = 1'b1;
         mem_raddr = data_next[AddrW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         label_mem[count_ff[AddrW-1:0]] <= q_item.name_char;
      end
      if (mem_re) begin
         rd_data_ff <= label_mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         held_valid_ff <= 1'b0;
         held_byte_ff  <= '0;
         overflow_ff   <= 1'b0;
         finish_ff     <= 1'b0;
         type_hold_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Drop the taken word unless a new one replaces it
         if (rsp_ready && !word_load) begin
            rsp_valid_ff <= 1'b0;
         end

         // Byte states: pair with the held byte or hold this one
         if ((state_ff == ST_FLUSH_LEN || state_ff == ST_FLUSH_DATA ||
              state_ff == ST_TRAIL) && byte_take) begin
            if (held_valid_ff) begin
               held_valid_ff <= 1'b0;
               rsp_valid_ff  <= 1'b1;
               rsp_word_ff   <= {held_byte_ff, cur_byte};
               rsp_count_ff  <= dqpb_pkg::COUNT_FULL;
               rsp_last_ff   <= cur_last;
               rsp_status_ff <= run_status;
            end else begin
               held_byte_ff  <= cur_byte;
               held_valid_ff <= 1'b1;
            end
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  unique case (q_item.op)
                     dqpb_pkg::OP_START: begin
                        count_ff      <= '0;
                        held_valid_ff <= 1'b0;
                        held_byte_ff  <= '0;
                        overflow_ff   <= 1'b0;
                        finish_ff     <= 1'b0;
                        type_hold_ff  <= q_item.query_type;
                        id_ff         <= q_item.query_id;
                        step_ff       <= '0;
                        state_ff      <= ST_HDR;
                     end
                     dqpb_pkg::OP_CHAR: begin
                        if (count_ff < LabelMaxC) begin
                           count_ff <= count_ff + 1'b1;
                        end else begin
                           overflow_ff <= 1'b1;
                        end
                     end
                     dqpb_pkg::OP_DOT: begin
                        finish_ff <= 1'b0;
                        if (count_ff != '0) begin
                           state_ff <= ST_FLUSH_LEN;
                        end
                     end
                     dqpb_pkg::OP_FINISH: begin
                        finish_ff <= 1'b1;
                        step_ff   <= '0;
                        state_ff  <= (count_ff != '0) ? ST_FLUSH_LEN : ST_TRAIL;
                     end
                     default: begin
                        state_ff <= ST_IDLE;
                     end
                  endcase
               end
            end
            ST_HDR: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_count_ff  <= dqpb_pkg::COUNT_FULL;
                  rsp_status_ff <= 1'b0;
                  rsp_last_ff   <= (step_ff == dqpb_pkg::HDR_LAST);
                  unique case (step_ff)
                     3'd0:    rsp_word_ff <= id_ff;
                     3'd1:    rsp_word_ff <= dqpb_pkg::FLAGS_WORD;
                     3'd2:    rsp_word_ff <= dqpb_pkg::QDCOUNT_WORD;
                     default: rsp_word_ff <= dqpb_pkg::ZERO_WORD;
                  endcase
                  step_ff <= step_ff + 3'd1;
                  if (step_ff == dqpb_pkg::HDR_LAST) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            ST_FLUSH_LEN: begin
               if (byte_take) begin
                  data_idx_ff <= '0;
                  state_ff    <= ST_FLUSH_DATA;
               end
            end
            ST_FLUSH_DATA: begin
               if (byte_take) begin
                  if (label_end) begin
                     count_ff <= '0;
                     step_ff  <= '0;
                     state_ff <= finish_ff ? ST_TRAIL : ST_IDLE;
                  end else begin
                     data_idx_ff <= data_next;
                  end
               end
            end
            ST_TRAIL: begin
               if (byte_take) begin
                  step_ff <= step_ff + 3'd1;
                  if (step_ff == dqpb_pkg::TRL_LAST) begin
                     if (held_valid_ff) begin
                        overflow_ff <= 1'b0;
                        finish_ff   <= 1'b0;
                        state_ff    <= ST_IDLE;
                     end else begin
                        state_ff <= ST_PAD;
                     end
                  end
               end
            end
            ST_PAD: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_word_ff   <= {held_byte_ff, dqpb_pkg::ZERO_BYTE};
                  rsp_count_ff  <= dqpb_pkg::COUNT_HALF;
                  rsp_last_ff   <= 1'b1;
                  rsp_status_ff <= run_status;
                  held_valid_ff <= 1'b0;
                  held_byte_ff  <= '0;
                  overflow_ff   <= 1'b0;
                  finish_ff     <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_word   = rsp_word_ff;
   assign rsp_byte_count = rsp_count_ff;
   assign rsp_last_word  = rsp_last_ff;
   assign rsp_status     = rsp_status_ff;

endmodule

`default_nettype wire

// ===== rtl/dns_query_packet_builder.sv =====
// Top level of the DNS query packet builder: front queue and back-end sequencer.
// A character request is buffered without output; a start request emits six header
// words; a dot or finish request streams the buffered label as packet bytes, finish
// also the trailer and, when it closes on a half word, a padded last word.
// Reset (synchronous, active high) empties the queue, drops any held byte and label.
`default_nettype none

module dns_query_packet_builder #(
   parameter int LABEL_MAX = 63
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [1:0]  req_cmd,
   input  wire  [7:0]  req_name_char,
   input  wire  [15:0] req_query_id,
   input  wire  [7:0]  req_query_type,
   // response channel
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [15:0] rsp_out_word,
   output logic [1:0]  rsp_byte_count,
   output logic        rsp_last_word,
   output logic        rsp_status
);

   // Classified requests waiting for the back end
   dqpb_pkg::item_type q_item;
   logic               q_valid;
   logic               q_ready;

   // Front: take requests, classify dots apart from label characters, drop
   // the unused command, and queue the rest so the back end may stall alone.
   dqpb_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_name_char  (req_name_char),
      .req_query_id   (req_query_id),
      .req_query_type (req_query_type),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item)
   );

   // Back: buffer label characters, then stream header, labels and trailer
   // as 16-bit words, holding an odd byte across requests.
   dqpb_back #(
      .LABEL_MAX (LABEL_MAX)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_ready        (q_ready),
      .q_item         (q_item),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_word   (rsp_out_word),
      .rsp_byte_count (rsp_byte_count),
      .rsp_last_word  (rsp_last_word),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

// ===== rtl/dqpb_checker.sv =====
// Port-level checks of the DNS query packet builder, bound to the top level.
`default_nettype none

module dqpb_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [15:0] rsp_out_word,
   input wire [1:0]  rsp_byte_count,
   input wire        rsp_last_word,
   input wire        rsp_status
);

   // Reset leaves no response pending
   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_count_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_byte_count == dqpb_pkg::COUNT_FULL ||
                     rsp_byte_count == dqpb_pkg::COUNT_HALF))
      else $error("byte count out of range");

   // A half word only closes a finish run and carries a zero low byte
   a_half_last : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_byte_count == dqpb_pkg::COUNT_HALF) |->
      (rsp_last_word && rsp_out_word[7:0] == dqpb_pkg::ZERO_BYTE))
      else $error("half word not last or low byte set");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_out_word) && $stable(rsp_byte_count) &&
       $stable(rsp_last_word) && $stable(rsp_status)))
      else $error("stalled response changed");

endmodule

bind dns_query_packet_builder dqpb_checker u_dqpb_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_word   (rsp_out_word),
   .rsp_byte_count (rsp_byte_count),
   .rsp_last_word  (rsp_last_word),
   .rsp_status     (rsp_status)
);

`default_nettype wire
